@@ src/bfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, filter range tables and constants for the band filter selector.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int BP_ENTRIES = 11;
  localparam int LP_ENTRIES = 7;
  localparam int BP_IDX_W   = $clog2(BP_ENTRIES);
  localparam int LP_IDX_W   = $clog2(LP_ENTRIES);

  localparam int FREQ_W    = 16;
  localparam int BP_CODE_W = 12;
  localparam int LP_CODE_W = 7;

  localparam logic [BP_CODE_W-1:0] BYPASS_CODE = 12'b1000_0000_0000;
  localparam logic [FREQ_W-1:0]    TOP_KHZ     = 16'd65535;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [FREQ_W-1:0]    lo;
    logic [FREQ_W-1:0]    hi;
    logic [BP_CODE_W-1:0] code;
  } bp_entry_t;

  typedef struct packed {
    logic [FREQ_W-1:0]    lo;
    logic [FREQ_W-1:0]    hi;
    logic [LP_CODE_W-1:0] code;
  } lp_entry_t;

  typedef struct packed {
    logic [BP_CODE_W-1:0] code;
    logic [FREQ_W-1:0]    lo;
    logic [FREQ_W-1:0]    hi;
  } bp_result_t;

  typedef struct packed {
    logic [LP_CODE_W-1:0] code;
    logic                 found;
  } lp_result_t;

  function automatic bp_entry_t bp_entry(input logic [BP_IDX_W-1:0] idx);
    bp_entry_t e;
    case (idx)
      4'd0:    e = '{16'd1750,  16'd2050,  12'h001};
      4'd1:    e = '{16'd3450,  16'd3850,  12'h002};
      4'd2:    e = '{16'd5200,  16'd5600,  12'h004};
      4'd3:    e = '{16'd6950,  16'd7250,  12'h008};
      4'd4:    e = '{16'd10000, 16'd10200, 12'h010};
      4'd5:    e = '{16'd13950, 16'd14400, 12'h020};
      4'd6:    e = '{16'd18000, 16'd18200, 12'h040};
      4'd7:    e = '{16'd20950, 16'd21500, 12'h080};
      4'd8:    e = '{16'd24800, 16'd25000, 12'h100};
      4'd9:    e = '{16'd27950, 16'd29750, 12'h200};
      4'd10:   e = '{16'd49500, 16'd52500, 12'h400};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic lp_entry_t lp_entry(input logic [LP_IDX_W-1:0] idx);
    lp_entry_t e;
    case (idx)
      3'd0:    e = '{16'd0,     16'd2050,  7'h01};
      3'd1:    e = '{16'd2051,  16'd3850,  7'h02};
      3'd2:    e = '{16'd3851,  16'd7250,  7'h04};
      3'd3:    e = '{16'd7251,  16'd14400, 7'h08};
      3'd4:    e = '{16'd14401, 16'd21500, 7'h10};
      3'd5:    e = '{16'd21501, 16'd29750, 7'h20};
      3'd6:    e = '{16'd29751, 16'd52500, 7'h40};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ src/bfs_bandpass.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_bandpass
// Range lookup of the receive frequency in the bandpass table, with bypass
// and gap limits outside the table entries.
// ----------------------------------------------------------------------------
module bfs_bandpass (
  input  wire logic [bfs_pkg::FREQ_W-1:0] freq,
  output bfs_pkg::bp_result_t             result
);
  import bfs_pkg::*;

  logic [BP_IDX_W-1:0] sel;
  bp_entry_t           first_e;
  bp_entry_t           last_e;
  bp_entry_t           sel_e;
  bp_entry_t           prev_e;

  always_comb begin
    sel = BP_IDX_W'(BP_ENTRIES - 1);
    for (int i = BP_ENTRIES - 1; i >= 0; i--) begin
      if (bp_entry(BP_IDX_W'(i)).hi >= freq) begin
        sel = BP_IDX_W'(i);
      end
    end
  end

  always_comb begin
    first_e = bp_entry('0);
    last_e  = bp_entry(BP_IDX_W'(BP_ENTRIES - 1));
    sel_e   = bp_entry(sel);
    prev_e  = bp_entry(sel - BP_IDX_W'(1));
    result  = '{BYPASS_CODE, '0, TOP_KHZ};
    if (freq < first_e.lo) begin
      result.hi = first_e.lo;
    end else if (freq > last_e.hi) begin
      result.lo = last_e.hi;
    end else if (freq >= sel_e.lo) begin
      result = '{sel_e.code, sel_e.lo, sel_e.hi};
    end else begin
      result.lo = (sel != '0) ? prev_e.hi + FREQ_W'(1) : '0;
      result.hi = sel_e.lo - FREQ_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ src/bfs_lowpass.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_lowpass
// Lowpass filter selection with a cached range; searches the table only when
// the transmit frequency leaves the range of the last filter found.
// ----------------------------------------------------------------------------
module bfs_lowpass (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic [bfs_pkg::FREQ_W-1:0] freq,
  output bfs_pkg::lp_result_t             result
);
  import bfs_pkg::*;

  logic [FREQ_W-1:0]    range_lo_r, range_lo_nxt;
  logic [FREQ_W-1:0]    range_hi_r, range_hi_nxt;
  logic                 found_r, found_nxt;
  logic [LP_CODE_W-1:0] code_r, code_nxt;

  logic [LP_IDX_W-1:0]  sel;
  logic                 hit;
  lp_entry_t            sel_e;

  always_comb begin
    sel = '0;
    hit = 1'b0;
    for (int i = LP_ENTRIES - 1; i >= 0; i--) begin
      if (lp_entry(LP_IDX_W'(i)).hi >= freq) begin
        sel = LP_IDX_W'(i);
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    sel_e        = lp_entry(sel);
    range_lo_nxt = range_lo_r;
    range_hi_nxt = range_hi_r;
    found_nxt    = found_r;
    code_nxt     = code_r;
    if (freq < range_lo_r || freq > range_hi_r) begin
      if (hit) begin
        range_lo_nxt = sel_e.lo;
        range_hi_nxt = sel_e.hi;
        found_nxt    = 1'b1;
        code_nxt     = sel_e.code;
      end else begin
        found_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_lo_r <= '0;
      range_hi_r <= '0;
      found_r    <= 1'b0;
      code_r     <= '0;
    end else if (advance) begin
      range_lo_r <= range_lo_nxt;
      range_hi_r <= range_hi_nxt;
      found_r    <= found_nxt;
      code_r     <= code_nxt;
    end
  end

  assign result = '{code_nxt, found_nxt};

endmodule
`default_nettype wire

@@ src/band_filter_selector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// band_filter_selector_top
// Pipeline: input register, then result register; an output stall holds both.
// Throughput: one item per cycle when the output does not stall; table
//   compares run in parallel in one stage.
// Reset: synchronous, active low; clears both stage valids and the cached
//   lowpass range, code and found flag.
// ----------------------------------------------------------------------------
module band_filter_selector_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [15:0] rx_freq_khz, [31:16] tx_freq_khz
  input  wire logic [bfs_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [11:0] rx_filter_code, [27:12] rx_band_low, [43:28] rx_band_high,
  // [50:44] tx_filter_code, [51] tx_filter_found, [55:52] zero
  output logic [bfs_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import bfs_pkg::*;

  logic                  in_v_r;
  logic [FREQ_W-1:0]     rx_r;
  logic [FREQ_W-1:0]     tx_r;
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  advance;
  bp_result_t            bp_res;
  lp_result_t            lp_res;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  bfs_bandpass u_bandpass (
    .freq   (rx_r),
    .result (bp_res)
  );

  bfs_lowpass u_lowpass (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .freq    (tx_r),
    .result  (lp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rx_r <= in_tdata[15:0];
      tx_r <= in_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {4'b0000, lp_res.found, lp_res.code, bp_res.hi, bp_res.lo, bp_res.code};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
